// ===== rtl/fbnp_pkg.sv =====
package fbnp_pkg;

	// Tree geometry
	localparam int ADDRS_PER_BLOCK = 1018;
	localparam int NIDS_PER_BLOCK  = 1018;

	localparam longint DBLKS  = longint'(ADDRS_PER_BLOCK);
	localparam longint IBLKS  = DBLKS * longint'(NIDS_PER_BLOCK);
	localparam longint DIBLKS = IBLKS * longint'(NIDS_PER_BLOCK);

	// Field widths
	localparam int IDX_W  = 32;
	localparam int SLOT_W = 10;
	localparam int NODE_W = 20;
	localparam int DEPTH_W = 2;
	localparam int OFS_W  = $clog2(DIBLKS);

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_ADDRS_PER_INODE = 1'b0;
	localparam logic REG_FIRST_NODE_SLOT = 1'b1;
	localparam logic [SLOT_W-1:0] RST_ADDRS_PER_INODE = SLOT_W'(923);
	localparam logic [SLOT_W-1:0] RST_FIRST_NODE_SLOT = SLOT_W'(924);

	// Region boundaries, counted from the end of the inode data slots
	localparam logic [IDX_W:0] T_DIR1 = (IDX_W+1)'(DBLKS);
	localparam logic [IDX_W:0] T_IND0 = (IDX_W+1)'(2 * DBLKS);
	localparam logic [IDX_W:0] T_IND1 = (IDX_W+1)'(2 * DBLKS + IBLKS);
	localparam logic [IDX_W:0] T_DIND = (IDX_W+1)'(2 * DBLKS + 2 * IBLKS);
	localparam logic [IDX_W:0] T_END  = (IDX_W+1)'(2 * DBLKS + 2 * IBLKS + DIBLKS);

	// Node numbers of the fixed nodes
	localparam logic [NODE_W-1:0] NN_DIR0  = NODE_W'(1);
	localparam logic [NODE_W-1:0] NN_DIR1  = NODE_W'(2);
	localparam logic [NODE_W-1:0] NN_IND0  = NODE_W'(3);
	localparam logic [NODE_W-1:0] NN_IND0C = NODE_W'(4);
	localparam logic [NODE_W-1:0] NN_IND1  = NODE_W'(4 + NIDS_PER_BLOCK);
	localparam logic [NODE_W-1:0] NN_IND1C = NODE_W'(5 + NIDS_PER_BLOCK);
	localparam logic [NODE_W-1:0] NN_DIND  = NODE_W'(5 + 2 * NIDS_PER_BLOCK);
	localparam logic [NODE_W-1:0] NN_DINDC = NODE_W'(6 + 2 * NIDS_PER_BLOCK);
	localparam logic [NODE_W-1:0] NN_STRIDE = NODE_W'(NIDS_PER_BLOCK + 1);

	// Depth codes
	localparam logic [DEPTH_W-1:0] DEPTH_INODE = 2'd0;
	localparam logic [DEPTH_W-1:0] DEPTH_DIR   = 2'd1;
	localparam logic [DEPTH_W-1:0] DEPTH_IND   = 2'd2;
	localparam logic [DEPTH_W-1:0] DEPTH_DIND  = 2'd3;

	typedef enum logic [2:0] {
		RG_INODE,
		RG_DIR0,
		RG_DIR1,
		RG_IND0,
		RG_IND1,
		RG_DIND,
		RG_NONE
	} region_t;

	// Side information that rides along the divider stages
	typedef struct packed {
		region_t           region;
		logic [SLOT_W-1:0] slot0;
		logic [SLOT_W-1:0] rem1;
	} ctl_t;

endpackage

// ===== rtl/file_block_to_node_path.sv =====
// Maps a 32-bit file block index to its path through the node tree: inode slot, offsets in up
// to three node levels and the logical node number of each node on the way. One index is taken
// in every clock cycle (busy stays low) and its result appears on the result ports, marked by
// done, for one cycle; the receiver cannot stall, so results must be captured when done is
// high. The pipeline is: input register, region compare, offset subtract, then two
// divide-by-constant units (reciprocal multiply plus a one-step correction, two stages each)
// and the result register. Registers addrs_per_inode (offset 0) and first_node_slot (offset 4)
// may be written only while no index is in flight.
module file_block_to_node_path
	import fbnp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [IDX_W-1:0]   block_index,
	output logic               done,
	output logic               not_found,
	output logic [DEPTH_W-1:0] depth,
	output logic [SLOT_W-1:0]  slot_level0,
	output logic [SLOT_W-1:0]  slot_level1,
	output logic [SLOT_W-1:0]  slot_level2,
	output logic [SLOT_W-1:0]  slot_level3,
	output logic [NODE_W-1:0]  node_number1,
	output logic [NODE_W-1:0]  node_number2,
	output logic [NODE_W-1:0]  node_number3,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int Q1_W = $clog2(((longint'(1) << OFS_W) - 1) / ADDRS_PER_BLOCK + 1);
	localparam int R1_W = $clog2(ADDRS_PER_BLOCK);
	localparam int Q2_W = $clog2(((longint'(1) << Q1_W) - 1) / NIDS_PER_BLOCK + 1);
	localparam int R2_W = $clog2(NIDS_PER_BLOCK);
	localparam int LATENCY = 8;

	logic [SLOT_W-1:0] addrs_per_inode;
	logic [SLOT_W-1:0] first_node_slot;
	logic              in_acc;

	logic              cls_vld;
	ctl_t              cls_ctl;
	logic [OFS_W-1:0]  cls_ofs;

	logic              d1_vld;
	ctl_t              d1_ctl;
	logic [Q1_W-1:0]   d1_quo;
	logic [R1_W-1:0]   d1_rem;
	ctl_t              d2_in_ctl;

	logic              d2_vld;
	ctl_t              d2_ctl;
	logic [Q2_W-1:0]   d2_quo;
	logic [R2_W-1:0]   d2_rem;

	assign busy   = 1'b0;
	assign in_acc = start & ~busy;

	fbnp_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.addrs_per_inode (addrs_per_inode),
		.first_node_slot (first_node_slot)
	);

	fbnp_classify u_classify (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_vld          (in_acc),
		.block_index     (block_index),
		.addrs_per_inode (addrs_per_inode),
		.first_node_slot (first_node_slot),
		.out_vld         (cls_vld),
		.out_ctl         (cls_ctl),
		.out_ofs         (cls_ofs)
	);

	// Split the offset into node index and data slot
	fbnp_divc #(
		.NUM_W (OFS_W),
		.DIV   (ADDRS_PER_BLOCK),
		.QUO_W (Q1_W),
		.REM_W (R1_W)
	) u_div_data (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (cls_vld),
		.in_ctl  (cls_ctl),
		.num     (cls_ofs),
		.out_vld (d1_vld),
		.out_ctl (d1_ctl),
		.quo     (d1_quo),
		.rem     (d1_rem)
	);

	// Carry the data slot along with the second split
	always_comb begin
		d2_in_ctl      = d1_ctl;
		d2_in_ctl.rem1 = SLOT_W'(d1_rem);
	end

	// Split the node index into indirect node and child slot
	fbnp_divc #(
		.NUM_W (Q1_W),
		.DIV   (NIDS_PER_BLOCK),
		.QUO_W (Q2_W),
		.REM_W (R2_W)
	) u_div_node (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (d1_vld),
		.in_ctl  (d2_in_ctl),
		.num     (d1_quo),
		.out_vld (d2_vld),
		.out_ctl (d2_ctl),
		.quo     (d2_quo),
		.rem     (d2_rem)
	);

	fbnp_result #(
		.QUO_W (Q2_W),
		.REM_W (R2_W)
	) u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (d2_vld),
		.in_ctl       (d2_ctl),
		.quo2         (d2_quo),
		.rem2         (d2_rem),
		.done         (done),
		.not_found    (not_found),
		.depth        (depth),
		.slot_level0  (slot_level0),
		.slot_level1  (slot_level1),
		.slot_level2  (slot_level2),
		.slot_level3  (slot_level3),
		.node_number1 (node_number1),
		.node_number2 (node_number2),
		.node_number3 (node_number3)
	);

	// Every accepted index yields a result word, marked by done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ##LATENCY done)
		else $error("result word missing after fixed latency");

	// Not found clears the depth, the inode slot, the first node number and its slot
	a_nf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && not_found |-> depth == DEPTH_INODE && slot_level0 == '0 &&
			node_number1 == '0 && slot_level1 == '0)
		else $error("not-found word carries path data");

	// Inode data slot has no nodes below it
	a_inode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !not_found && depth == DEPTH_INODE |->
			node_number1 == '0 && node_number2 == '0 && node_number3 == '0)
		else $error("inode data slot with node numbers set");

	// Third-level node follows its parent in depth-first order
	a_dind_chain: assert property (@(posedge clk) disable iff (!arst_n)
		done && depth == DEPTH_DIND |->
			node_number3 == NODE_W'(node_number2 + NODE_W'(1) + NODE_W'(slot_level2)))
		else $error("double-indirect node numbering broken");

endmodule

// ===== rtl/fbnp_cfg.sv =====
module fbnp_cfg
	import fbnp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [SLOT_W-1:0]  addrs_per_inode,
	output logic [SLOT_W-1:0]  first_node_slot
);

	logic [SLOT_W-1:0] api_q;
	logic [SLOT_W-1:0] fns_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			api_q <= RST_ADDRS_PER_INODE;
			fns_q <= RST_FIRST_NODE_SLOT;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ADDRS_PER_INODE: api_q <= pwdata[SLOT_W-1:0];
				REG_FIRST_NODE_SLOT: fns_q <= pwdata[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			REG_ADDRS_PER_INODE: prdata = PDATA_W'(api_q);
			REG_FIRST_NODE_SLOT: prdata = PDATA_W'(fns_q);
			default:             prdata = '0;
		endcase
	end

	assign addrs_per_inode = api_q;
	assign first_node_slot = fns_q;

endmodule

// ===== rtl/fbnp_classify.sv =====
module fbnp_classify
	import fbnp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [IDX_W-1:0]  block_index,
	input  logic [SLOT_W-1:0] addrs_per_inode,
	input  logic [SLOT_W-1:0] first_node_slot,
	output logic              out_vld,
	output ctl_t              out_ctl,
	output logic [OFS_W-1:0]  out_ofs
);

	logic              vld_s1, vld_s2, vld_s3;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  bp_s2;
	ctl_t              ctl_s2, ctl_s3;
	logic [OFS_W-1:0]  ofs_s3;

	logic [IDX_W-1:0]  bp;
	logic [IDX_W:0]    bp_x;
	region_t           region;
	logic [SLOT_W-1:0] slot0;
	logic [IDX_W:0]    base;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (in_vld) idx_s1 <= block_index;
	end

	// Find the region past the inode data slots
	assign bp   = idx_s1 - IDX_W'(addrs_per_inode);
	assign bp_x = {1'b0, bp};

	always_comb begin
		if (idx_s1 < IDX_W'(addrs_per_inode)) region = RG_INODE;
		else if (bp_x < T_DIR1)               region = RG_DIR0;
		else if (bp_x < T_IND0)               region = RG_DIR1;
		else if (bp_x < T_IND1)               region = RG_IND0;
		else if (bp_x < T_DIND)               region = RG_IND1;
		else if (bp_x < T_END)                region = RG_DIND;
		else                                  region = RG_NONE;
	end

	// Pick the inode slot: data slot or node pointer slot
	always_comb begin
		unique case (region)
			RG_INODE: slot0 = idx_s1[SLOT_W-1:0];
			RG_DIR0:  slot0 = first_node_slot;
			RG_DIR1:  slot0 = first_node_slot + SLOT_W'(1);
			RG_IND0:  slot0 = first_node_slot + SLOT_W'(2);
			RG_IND1:  slot0 = first_node_slot + SLOT_W'(3);
			RG_DIND:  slot0 = first_node_slot + SLOT_W'(4);
			default:  slot0 = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		bp_s2         <= bp;
		ctl_s2.region <= region;
		ctl_s2.slot0  <= slot0;
		ctl_s2.rem1   <= '0;
	end

	// Offset within the region
	always_comb begin
		unique case (ctl_s2.region)
			RG_DIR1: base = T_DIR1;
			RG_IND0: base = T_IND0;
			RG_IND1: base = T_IND1;
			RG_DIND: base = T_DIND;
			default: base = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		ctl_s3 <= ctl_s2;
		ofs_s3 <= OFS_W'(bp_s2 - base[IDX_W-1:0]);
	end

	assign out_vld = vld_s3;
	assign out_ctl = ctl_s3;
	assign out_ofs = ofs_s3;

endmodule

// ===== rtl/fbnp_divc.sv =====
module fbnp_divc
	import fbnp_pkg::*;
#(
	parameter int NUM_W = OFS_W,
	parameter int DIV   = ADDRS_PER_BLOCK,
	parameter int QUO_W = $clog2(((longint'(1) << NUM_W) - 1) / DIV + 1),
	parameter int REM_W = $clog2(DIV)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  ctl_t             in_ctl,
	input  logic [NUM_W-1:0] num,
	output logic             out_vld,
	output ctl_t             out_ctl,
	output logic [QUO_W-1:0] quo,
	output logic [REM_W-1:0] rem
);

	// Reciprocal scaled by 2**NUM_W; the estimate is low by at most one
	localparam longint RECIP = (longint'(1) << NUM_W) / DIV;
	localparam int     MUL_W = $clog2(RECIP + 1);
	localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);
	localparam logic [NUM_W-1:0] DIV_C   = NUM_W'(DIV);

	logic [NUM_W+MUL_W-1:0] prod;
	logic                   vld_s1, vld_s2;
	ctl_t                   ctl_s1, ctl_s2;
	logic [NUM_W-1:0]       num_s1;
	logic [QUO_W-1:0]       qe_s1;
	logic [QUO_W-1:0]       quo_s2;
	logic [REM_W-1:0]       rem_s2;
	logic [NUM_W-1:0]       qd;
	logic [NUM_W-1:0]       diff;
	logic                   fix;

	// Estimate the quotient
	assign prod = {{MUL_W{1'b0}}, num} * {{NUM_W{1'b0}}, RECIP_C};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= in_ctl;
		num_s1 <= num;
		qe_s1  <= prod[NUM_W +: QUO_W];
	end

	// Correct the estimate by one step
	assign qd   = NUM_W'(qe_s1) * DIV_C;
	assign diff = num_s1 - qd;
	assign fix  = (diff >= DIV_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		quo_s2 <= fix ? qe_s1 + QUO_W'(1) : qe_s1;
		rem_s2 <= fix ? REM_W'(diff - DIV_C) : REM_W'(diff);
	end

	assign out_vld = vld_s2;
	assign out_ctl = ctl_s2;
	assign quo     = quo_s2;
	assign rem     = rem_s2;

endmodule

// ===== rtl/fbnp_result.sv =====
module fbnp_result
	import fbnp_pkg::*;
#(
	parameter int QUO_W = 2,
	parameter int REM_W = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  ctl_t               in_ctl,
	input  logic [QUO_W-1:0]   quo2,
	input  logic [REM_W-1:0]   rem2,
	output logic               done,
	output logic               not_found,
	output logic [DEPTH_W-1:0] depth,
	output logic [SLOT_W-1:0]  slot_level0,
	output logic [SLOT_W-1:0]  slot_level1,
	output logic [SLOT_W-1:0]  slot_level2,
	output logic [SLOT_W-1:0]  slot_level3,
	output logic [NODE_W-1:0]  node_number1,
	output logic [NODE_W-1:0]  node_number2,
	output logic [NODE_W-1:0]  node_number3
);

	logic               done_q;
	logic               nf_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [SLOT_W-1:0]  s0_q, s1_q, s2_q, s3_q;
	logic [NODE_W-1:0]  nn1_q, nn2_q, nn3_q;

	logic               nf;
	logic [DEPTH_W-1:0] dep;
	logic [SLOT_W-1:0]  s0, s1, s2, s3;
	logic [NODE_W-1:0]  nn1, nn2, nn3;
	logic [NODE_W-1:0]  q2_n, r2_n, dind_nn2;

	// Below an indirect node the quotient is zero and rem2 holds the child index
	assign q2_n     = NODE_W'(quo2);
	assign r2_n     = NODE_W'(rem2);
	assign dind_nn2 = NN_DINDC + q2_n * NN_STRIDE;

	// Assemble the word
	always_comb begin
		nf  = 1'b0;
		dep = DEPTH_INODE;
		s0  = in_ctl.slot0;
		s1  = '0;
		s2  = '0;
		s3  = '0;
		nn1 = '0;
		nn2 = '0;
		nn3 = '0;
		unique case (in_ctl.region)
			RG_INODE: ;
			RG_DIR0: begin
				dep = DEPTH_DIR;
				nn1 = NN_DIR0;
				s1  = in_ctl.rem1;
			end
			RG_DIR1: begin
				dep = DEPTH_DIR;
				nn1 = NN_DIR1;
				s1  = in_ctl.rem1;
			end
			RG_IND0: begin
				dep = DEPTH_IND;
				nn1 = NN_IND0;
				s1  = SLOT_W'(rem2);
				nn2 = NN_IND0C + r2_n;
				s2  = in_ctl.rem1;
			end
			RG_IND1: begin
				dep = DEPTH_IND;
				nn1 = NN_IND1;
				s1  = SLOT_W'(rem2);
				nn2 = NN_IND1C + r2_n;
				s2  = in_ctl.rem1;
			end
			RG_DIND: begin
				dep = DEPTH_DIND;
				nn1 = NN_DIND;
				s1  = SLOT_W'(quo2);
				nn2 = dind_nn2;
				s2  = SLOT_W'(rem2);
				nn3 = dind_nn2 + NODE_W'(1) + r2_n;
				s3  = in_ctl.rem1;
			end
			default: begin
				nf = 1'b1;
				s0 = '0;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= in_vld;
	end

	always_ff @(posedge clk) begin
		nf_q    <= nf;
		depth_q <= dep;
		s0_q    <= s0;
		s1_q    <= s1;
		s2_q    <= s2;
		s3_q    <= s3;
		nn1_q   <= nn1;
		nn2_q   <= nn2;
		nn3_q   <= nn3;
	end

	assign done         = done_q;
	assign not_found    = nf_q;
	assign depth        = depth_q;
	assign slot_level0  = s0_q;
	assign slot_level1  = s1_q;
	assign slot_level2  = s2_q;
	assign slot_level3  = s3_q;
	assign node_number1 = nn1_q;
	assign node_number2 = nn2_q;
	assign node_number3 = nn3_q;

endmodule

// ===== tb/sv/file_block_to_node_path_check.sv =====
`timescale 1ns / 100ps

module file_block_to_node_path_check
	import fbnp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [IDX_W-1:0]   block_index,
	input  logic               done,
	input  logic               not_found,
	input  logic [DEPTH_W-1:0] depth,
	input  logic [SLOT_W-1:0]  slot_level0,
	input  logic [SLOT_W-1:0]  slot_level1,
	input  logic [SLOT_W-1:0]  slot_level2,
	input  logic [SLOT_W-1:0]  slot_level3,
	input  logic [NODE_W-1:0]  node_number1,
	input  logic [NODE_W-1:0]  node_number2,
	input  logic [NODE_W-1:0]  node_number3,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		logic                   not_found;
		logic [DEPTH_W-1:0]     depth;
		logic [3:0][SLOT_W-1:0] slot;
		logic [3:1][NODE_W-1:0] node;
	} node_path_t;

	node_path_t        paths_due[$];
	logic [SLOT_W-1:0] inode_addrs;
	logic [SLOT_W-1:0] ptr_base;
	int                errors;

	// Walk the tree regions in order and build the node path of one index
	function automatic node_path_t node_path_of(input logic [IDX_W-1:0] idx);
		longint unsigned dblks, nids, iblks, diblks, b, up, mid;
		node_path_t p;
		dblks = ADDRS_PER_BLOCK;
		nids = NIDS_PER_BLOCK;
		iblks = dblks * nids;
		diblks = iblks * nids;
		p = '0;
		b = idx;
		if (b < inode_addrs) begin
			p.depth = DEPTH_INODE;
			p.slot[0] = SLOT_W'(b);
		end else begin
			b -= inode_addrs;
			if (b < dblks) begin
				p.depth = DEPTH_DIR;
				p.slot[0] = ptr_base;
				p.node[1] = NODE_W'(1);
				p.slot[1] = SLOT_W'(b);
			end else if (b < 2 * dblks) begin
				b -= dblks;
				p.depth = DEPTH_DIR;
				p.slot[0] = ptr_base + SLOT_W'(1);
				p.node[1] = NODE_W'(2);
				p.slot[1] = SLOT_W'(b);
			end else if (b < 2 * dblks + iblks) begin
				b -= 2 * dblks;
				up = b / dblks;
				p.depth = DEPTH_IND;
				p.slot[0] = ptr_base + SLOT_W'(2);
				p.node[1] = NODE_W'(3);
				p.slot[1] = SLOT_W'(up);
				p.node[2] = NODE_W'(4 + up);
				p.slot[2] = SLOT_W'(b % dblks);
			end else if (b < 2 * dblks + 2 * iblks) begin
				b -= 2 * dblks + iblks;
				up = b / dblks;
				p.depth = DEPTH_IND;
				p.slot[0] = ptr_base + SLOT_W'(3);
				p.node[1] = NODE_W'(4 + nids);
				p.slot[1] = SLOT_W'(up);
				p.node[2] = NODE_W'(5 + nids + up);
				p.slot[2] = SLOT_W'(b % dblks);
			end else if (b < 2 * dblks + 2 * iblks + diblks) begin
				b -= 2 * dblks + 2 * iblks;
				up = b / iblks;
				mid = (b / dblks) % nids;
				p.depth = DEPTH_DIND;
				p.slot[0] = ptr_base + SLOT_W'(4);
				p.node[1] = NODE_W'(5 + 2 * nids);
				p.slot[1] = SLOT_W'(up);
				p.node[2] = NODE_W'(6 + 2 * nids + up * (nids + 1));
				p.slot[2] = SLOT_W'(mid);
				p.node[3] = NODE_W'(7 + 2 * nids + up * (nids + 1) + mid);
				p.slot[3] = SLOT_W'(b % dblks);
			end else begin
				p.not_found = 1'b1;
			end
		end
		return p;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		node_path_t want;
		if (!arst_n) begin
			paths_due.delete();
			inode_addrs = RST_ADDRS_PER_INODE;
			ptr_base = RST_FIRST_NODE_SLOT;
			errors = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			// compare the result word with the oldest expected path
			if (done === 1'b1) begin
				if (paths_due.size() == 0) begin
					$display("%0t unexpected result word: expected none, got not_found=%0b depth=%0d",
						$time, not_found, depth);
					errors++;
				end else begin
					want = paths_due.pop_front();
					check_field("not_found", want.not_found, not_found);
					check_field("depth", want.depth, depth);
					check_field("slot_level0", want.slot[0], slot_level0);
					check_field("slot_level1", want.slot[1], slot_level1);
					check_field("slot_level2", want.slot[2], slot_level2);
					check_field("slot_level3", want.slot[3], slot_level3);
					check_field("node_number1", want.node[1], node_number1);
					check_field("node_number2", want.node[2], node_number2);
					check_field("node_number3", want.node[3], node_number3);
				end
			end

			// predict each accepted index word
			if (start === 1'b1 && busy === 1'b0)
				paths_due = {paths_due, node_path_of(block_index)};

			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_ADDRS_PER_INODE, 2'b00})
					inode_addrs = pwdata[SLOT_W-1:0];
				else if (paddr == {REG_FIRST_NODE_SLOT, 2'b00})
					ptr_base = pwdata[SLOT_W-1:0];
			end

			outstanding <= paths_due.size();
			mismatches <= errors;
		end
	end

endmodule

// ===== tb/sv/file_block_to_node_path_test.sv =====
`timescale 1ns / 100ps

module file_block_to_node_path_test;
	import fbnp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 330;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [IDX_W-1:0]   block_index = '0;
	logic               done;
	logic               not_found;
	logic [DEPTH_W-1:0] depth;
	logic [SLOT_W-1:0]  slot_level0;
	logic [SLOT_W-1:0]  slot_level1;
	logic [SLOT_W-1:0]  slot_level2;
	logic [SLOT_W-1:0]  slot_level3;
	logic [NODE_W-1:0]  node_number1;
	logic [NODE_W-1:0]  node_number2;
	logic [NODE_W-1:0]  node_number3;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 mismatches;
	int                 outstanding;
	int                 cycles = 0;
	logic               gaps_on = 1'b1;
	logic [SLOT_W-1:0]  cur_addrs = RST_ADDRS_PER_INODE;

	always #4 clk = ~clk;

	file_block_to_node_path uut (.*);

	file_block_to_node_path_check path_check (.*);

	// Hold start high until the index word is taken; idle in random bursts
	task automatic send_index(input logic [IDX_W-1:0] idx);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1'b1;
		block_index <= idx;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Drop start and wait for every expected path to arrive
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [SLOT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Aim most indexes at a tree region or a region edge, the rest anywhere
	function automatic logic [IDX_W-1:0] random_index(input logic [SLOT_W-1:0] addrs);
		longint unsigned lo;
		longint unsigned bounds [6];
		int kind;
		lo = addrs;
		bounds = '{lo, lo + T_DIR1, lo + T_IND0, lo + T_IND1, lo + T_DIND, lo + T_END};
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				if (addrs != 0)
					return IDX_W'($urandom_range(0, addrs - 1));
			end
			1: return IDX_W'(lo + $urandom_range(0, 2 * ADDRS_PER_BLOCK - 1));
			2: return IDX_W'(lo + T_IND0 + ($urandom % (2 * IBLKS)));
			3, 4, 5: return IDX_W'(lo + T_DIND + ($urandom % DIBLKS));
			6: return IDX_W'(bounds[$urandom_range(0, 5)] + $urandom_range(0, 3) - 2);
			7: return IDX_W'($urandom_range(32'(lo + T_END), 32'hFFFF_FFFF));
			default: ;
		endcase
		return $urandom;
	endfunction

	initial begin
		longint unsigned   edges [16];
		logic [SLOT_W-1:0] addrs_set [PHASES];
		logic [SLOT_W-1:0] base_set [PHASES];
		longint unsigned   lo;

		lo = RST_ADDRS_PER_INODE;
		edges = '{0, lo - 1, lo, lo + T_DIR1 - 1, lo + T_DIR1, lo + T_IND0 - 1, lo + T_IND0,
			lo + T_IND0 + DBLKS, lo + T_IND1 - 1, lo + T_IND1, lo + T_DIND - 1, lo + T_DIND,
			lo + T_DIND + IBLKS, lo + T_END - 1, lo + T_END, 64'hFFFF_FFFF};
		addrs_set = '{RST_ADDRS_PER_INODE, SLOT_W'(0), SLOT_W'(1023), SLOT_W'(1),
			SLOT_W'($urandom_range(0, 1023)), RST_ADDRS_PER_INODE};
		base_set = '{RST_FIRST_NODE_SLOT, SLOT_W'(0), SLOT_W'(1023), SLOT_W'(1021),
			SLOT_W'($urandom_range(0, 1023)), RST_FIRST_NODE_SLOT};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// region edges under the reset settings
		foreach (edges[i])
			send_index(IDX_W'(edges[i]));

		for (int ph = 0; ph < PHASES; ph++) begin
			// reconfigure only once the block is idle
			if (ph > 0) begin
				drain();
				write_reg(REG_ADDRS_PER_INODE, addrs_set[ph]);
				write_reg(REG_FIRST_NODE_SLOT, base_set[ph]);
				cur_addrs = addrs_set[ph];
			end
			gaps_on = (ph != PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 2 && i == PHASE_ITEMS / 2)
					drain();
				send_index(random_index(cur_addrs));
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// End the run once the cycle limit is reached, as when the block stops answering
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
